// ===== design/olq_pkg.sv =====
// ----------------------------------------------------------------------------
// olq_pkg: shared types and codes for the ordered list unit
// Action codes, status codes, cell operations and the cell control word.
// ----------------------------------------------------------------------------
package olq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W     = 32;
  localparam int ENTRIES_W  = 5;

  // input actions; codes six and seven leave the list unchanged and report ok
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REMOVE     = 3'd4,
    ACT_LIST       = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   bus;
  } cell_ctrl_t;

endpackage

// ===== design/olq_cell.sv =====
// ----------------------------------------------------------------------------
// olq_cell: one entry of the list chain
// Holds one value and its occupancy bit, and moves data to and from its
// neighbors as the broadcast operation asks.
// ----------------------------------------------------------------------------
module olq_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  olq_pkg::cell_ctrl_t        ctrl,
  input  logic [olq_pkg::DATA_W-1:0] left_data,
  input  logic                       left_valid,
  input  logic [olq_pkg::DATA_W-1:0] right_data,
  input  logic                       right_valid,
  input  logic                       hit_in,
  output logic [olq_pkg::DATA_W-1:0] data,
  output logic                       valid,
  output logic                       hit_out,
  output logic [olq_pkg::DATA_W-1:0] pick
);
  import olq_pkg::*;

  logic                is_tail;
  logic                take_right;
  logic [DATA_W-1:0]   data_next;
  logic                valid_next;

  assign is_tail = valid && !right_valid;

  // mark this cell and every cell behind the first match
  assign hit_out = hit_in || (valid && (data == ctrl.bus));

  // expose the tail value for a remove from the back
  assign pick = is_tail ? data : '0;

  assign take_right = (ctrl.op == OP_POP_FRONT) || ((ctrl.op == OP_REMOVE) && hit_out);

  // next value and occupancy
  always_comb begin
    data_next  = data;
    valid_next = valid;
    case (ctrl.op)
      OP_PUSH_FRONT: begin
        data_next  = left_data;
        valid_next = left_valid;
      end
      OP_PUSH_BACK: begin
        if (!valid && left_valid) begin
          data_next  = ctrl.bus;
          valid_next = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_tail) begin
          valid_next = 1'b0;
        end
      end
      OP_ROTATE: begin
        if (valid) begin
          data_next = right_valid ? right_data : ctrl.bus;
        end
      end
      default: begin
        if (take_right) begin
          data_next  = right_data;
          valid_next = right_valid;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// ===== design/ordered_list_deque_with_removal_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_list_deque_with_removal_unit: bounded ordered list of 32-bit values
// Inserts, removes (front, back, by value) and a full listing, held in a chain
// of DEPTH cells with the front entry in cell zero.
// The single result of any action other than list is registered and comes in the cycle after accept.
// One action is accepted per cycle while busy is low; a list of N entries holds busy while
// it gives its N results one per cycle, by rotating the chain.
// Results are strobed by done for one cycle each; the receiver cannot stall.
// Reset empties the list; cell contents are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_deque_with_removal_unit #(
  parameter int DEPTH = olq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        action,
  input  logic signed [olq_pkg::DATA_W-1:0] value,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [olq_pkg::DATA_W-1:0] item,
  output logic [olq_pkg::ENTRIES_W-1:0]     entries,
  output logic                              last
);
  import olq_pkg::*;

  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  cell_ctrl_t          ctrl;
  logic [DATA_W-1:0]   cell_data  [DEPTH];
  logic                cell_valid [DEPTH];
  logic                cell_hit   [DEPTH];
  logic [DATA_W-1:0]   cell_pick  [DEPTH];
  logic [DATA_W-1:0]   tail_data;

  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    len_next;
  logic                listing;
  logic                listing_next;
  logic [IDX_W-1:0]    list_idx;
  logic [IDX_W-1:0]    list_idx_next;
  logic                list_final;

  logic                res_emit;
  status_t             res_status;
  logic [DATA_W-1:0]   res_item;
  logic                res_last;

  logic                accept;
  logic                full;
  logic                empty;
  logic                found;

  assign accept = start && !busy;
  assign busy   = listing;
  assign full   = (len == LEN_W'(DEPTH));
  assign empty  = (len == '0);
  assign found  = cell_hit[DEPTH-1];
  assign list_final = ((LEN_W'(list_idx) + LEN_W'(1)) == len);

  // chain of cells, front at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] l_data;
    logic              l_valid;
    logic [DATA_W-1:0] r_data;
    logic              r_valid;
    logic              h_in;

    if (i == 0) begin : g_front
      assign l_data  = ctrl.bus;
      assign l_valid = 1'b1;
      assign h_in    = 1'b0;
    end else begin : g_inner
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
      assign h_in    = cell_hit[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    olq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .hit_in      (h_in),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .hit_out     (cell_hit[i]),
      .pick        (cell_pick[i])
    );
  end

  // gather the tail value; only one cell drives a nonzero pick
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | cell_pick[i];
    end
  end

  // decode the action, drive the chain and form the result
  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.bus      = value;
    len_next      = len;
    listing_next  = listing;
    list_idx_next = list_idx;
    res_emit      = 1'b0;
    res_status    = ST_OK;
    res_item      = '0;
    res_last      = 1'b1;
    if (listing) begin
      ctrl.op       = OP_ROTATE;
      ctrl.bus      = cell_data[0];
      res_emit      = 1'b1;
      res_item      = cell_data[0];
      res_last      = list_final;
      list_idx_next = list_idx + IDX_W'(1);
      if (list_final) begin
        listing_next  = 1'b0;
        list_idx_next = '0;
      end
    end else if (accept) begin
      res_emit = 1'b1;
      unique case (action_t'(action))
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            ctrl.op  = (action_t'(action) == ACT_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            len_next = len + LEN_W'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            ctrl.op  = OP_POP_FRONT;
            res_item = cell_data[0];
            len_next = len - LEN_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            ctrl.op  = OP_POP_BACK;
            res_item = tail_data;
            len_next = len - LEN_W'(1);
          end
        end
        ACT_REMOVE: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else if (!found) begin
            res_status = ST_NOTFOUND;
          end else begin
            ctrl.op  = OP_REMOVE;
            res_item = value;
            len_next = len - LEN_W'(1);
          end
        end
        ACT_LIST: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_emit      = 1'b0;
            listing_next  = 1'b1;
            list_idx_next = '0;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      listing  <= 1'b0;
      list_idx <= '0;
      done     <= 1'b0;
    end else begin
      len      <= len_next;
      listing  <= listing_next;
      list_idx <= list_idx_next;
      done     <= res_emit;
    end
  end

  // register the result: status, item, entry count and last flag
  always_ff @(posedge clk) begin
    if (res_emit) begin
      status  <= res_status;
      item    <= res_item;
      entries <= ENTRIES_W'(len_next);
      last    <= res_last;
    end
  end

endmodule
